### rtl/rgl_pkg.sv
// Shared constants for the running GCD / LCM reduction block.
// No dependencies.
`default_nettype none
package rgl_pkg;
	localparam int LCM_BITS = 31;
	localparam logic [LCM_BITS-1:0] LCM_MAX = '1;
	localparam int GCD_OUT_BITS = 32;
endpackage
`default_nettype wire

### rtl/rgl_front.sv
// Front end: takes the signed value, forms its magnitude and classifies it.
// Depends on rgl_pkg.
`default_nettype none
module rgl_front #(
	parameter int VALUE_WIDTH = 32,
	parameter int GW = 32
) (
	input  wire logic [VALUE_WIDTH-1:0] value,
	output logic [GW-1:0] mag,
	output logic is_zero,
	output logic over_max
);
	logic [VALUE_WIDTH-1:0] neg;

	// Two's complement magnitude; the most negative value keeps its top bit
	assign neg = (~value) + VALUE_WIDTH'(1);
	assign mag = GW'(value[VALUE_WIDTH-1] ? neg : value);
	assign is_zero = (value == '0);
	assign over_max = (mag > GW'(rgl_pkg::LCM_MAX));
endmodule
`default_nettype wire

### rtl/rgl_fifo.sv
// Two-entry queue between the front end and the arithmetic back end.
// No dependencies.
`default_nettype none
module rgl_fifo #(
	parameter int WIDTH = 35
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic full,
	input  wire logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic not_empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	// Store on push
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end
endmodule
`default_nettype wire

### rtl/rgl_gcd.sv
// Iterative binary GCD unit, one halving or subtraction per cycle.
// No dependencies.
`default_nettype none
module rgl_gcd #(
	parameter int WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [WIDTH-1:0] a,
	input  wire logic [WIDTH-1:0] b,
	output logic busy,
	output logic [WIDTH-1:0] result
);
	localparam int KW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] a_q, b_q, res_q;
	logic [KW-1:0] k_q;
	logic busy_q;

	assign busy = busy_q;
	assign result = res_q;

	// Operand registers and the shared power of two
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			k_q <= '0;
		end else if (busy_q) begin
			if (a_q == '0) begin
				res_q <= b_q << k_q;
			end else if (b_q == '0) begin
				res_q <= a_q << k_q;
			end else if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q >= b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end
	end

	// Drop busy once either operand reaches zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b0;
		else if (start) busy_q <= 1'b1;
		else if (busy_q && (a_q == '0 || b_q == '0)) busy_q <= 1'b0;
	end
endmodule
`default_nettype wire

### rtl/rgl_back.sv
// Back end: folds each queued magnitude into the running GCD and LCM.
// Depends on rgl_pkg and rgl_gcd.
`default_nettype none
module rgl_back #(
	parameter int GW = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	input  wire logic [GW-1:0] item_mag,
	input  wire logic item_zero,
	input  wire logic item_over,
	input  wire logic item_last,
	output logic item_pop,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [31:0] gcd_result,
	output logic [30:0] lcm_result,
	output logic lcm_overflow
);
	localparam int LB = rgl_pkg::LCM_BITS;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GCD  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_CHK  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [GW-1:0] acc_g_q, m_q;
	logic [LB-1:0] acc_l_q, dvd_q, dvs_q, rem_q;
	logic started_q, ovf_q, last_q, zero_q, over_q;
	logic [4:0] cnt_q;
	logic [2*LB-1:0] prod_q;
	logic [LB:0] trial;
	logic trial_ge;
	logic gcd_start, busy_g, busy_l;
	logic [GW-1:0] res_g, res_l;
	logic out_valid_q;
	logic [31:0] gcd_out_q;
	logic [LB-1:0] lcm_out_q;
	logic ovf_out_q;
	logic out_free;

	assign item_pop = (state_q == S_IDLE) && item_valid;
	assign gcd_start = item_pop && started_q;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign gcd_result = gcd_out_q;
	assign lcm_result = lcm_out_q;
	assign lcm_overflow = ovf_out_q;

	// Restoring division step
	assign trial = {rem_q, dvd_q[LB-1]};
	assign trial_ge = (trial >= {1'b0, dvs_q});

	rgl_gcd #(.WIDTH(GW)) u_gcd_g (
		.clk(clk), .arst_n(arst_n), .start(gcd_start),
		.a(acc_g_q), .b(item_mag), .busy(busy_g), .result(res_g)
	);

	rgl_gcd #(.WIDTH(GW)) u_gcd_l (
		.clk(clk), .arst_n(arst_n), .start(gcd_start),
		.a(GW'(acc_l_q)), .b(item_mag), .busy(busy_l), .result(res_l)
	);

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					m_q <= item_mag;
					zero_q <= item_zero;
					over_q <= item_over;
				end
			end
			S_GCD: begin
				rem_q <= '0;
				dvd_q <= acc_l_q;
				dvs_q <= res_l[LB-1:0];
			end
			S_DIV: begin
				rem_q <= trial_ge ? LB'(trial - {1'b0, dvs_q}) : trial[LB-1:0];
				dvd_q <= {dvd_q[LB-2:0], trial_ge};
			end
			S_MUL: prod_q <= dvd_q * m_q[LB-1:0];
			default: ;
		endcase
		if (state_q == S_FIN && last_q && out_free) begin
			gcd_out_q <= 32'(acc_g_q);
			lcm_out_q <= acc_l_q;
			ovf_out_q <= ovf_q;
		end
	end

	// Sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_g_q <= '0;
			acc_l_q <= '0;
			started_q <= 1'b0;
			ovf_q <= 1'b0;
			last_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						last_q <= item_last;
						if (!started_q) begin
							started_q <= 1'b1;
							acc_g_q <= item_mag;
							if (item_over) begin
								acc_l_q <= rgl_pkg::LCM_MAX;
								ovf_q <= 1'b1;
							end else begin
								acc_l_q <= LB'(item_mag);
							end
							state_q <= S_FIN;
						end else begin
							state_q <= S_GCD;
						end
					end
				end
				S_GCD: begin
					if (!busy_g && !busy_l) begin
						acc_g_q <= res_g;
						cnt_q <= '0;
						if (acc_l_q == '0 || zero_q) begin
							acc_l_q <= '0;
							state_q <= S_FIN;
						end else if (over_q) begin
							acc_l_q <= rgl_pkg::LCM_MAX;
							ovf_q <= 1'b1;
							state_q <= S_FIN;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(LB - 1)) state_q <= S_MUL;
				end
				S_MUL: state_q <= S_CHK;
				S_CHK: begin
					if (prod_q > (2*LB)'(rgl_pkg::LCM_MAX)) begin
						acc_l_q <= rgl_pkg::LCM_MAX;
						ovf_q <= 1'b1;
					end else begin
						acc_l_q <= prod_q[LB-1:0];
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						acc_g_q <= '0;
						acc_l_q <= '0;
						started_q <= 1'b0;
						ovf_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/running_gcd_lcm_reduce.sv
// Running GCD and LCM over runs of signed integers. Each transaction carries
// one value and a last mark; one result (GCD, saturated LCM, sticky overflow)
// leaves on the transaction marked last, and the running state then clears.
// Input is queued two deep so the front keeps accepting while the back end
// works, until the queue is full. Each item runs binary GCD (the two GCD
// units run side by side), then restoring division, then multiply, check
// and hand-off. The first item of a run goes straight to hand-off, and a
// zero value ends the GCD on its first step and skips the division; once
// the running LCM is zero, or the magnitude alone exceeds the LCM limit,
// the division is skipped but the GCD still runs in full.
// Depends on rgl_pkg, rgl_front, rgl_fifo, rgl_gcd and rgl_back.
`default_nettype none
module running_gcd_lcm_reduce #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [VALUE_WIDTH-1:0] value,
	input  wire logic last,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [31:0] gcd_result,
	output logic [30:0] lcm_result,
	output logic lcm_overflow
);
	localparam int GW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
	localparam int EW = GW + 3;

	logic [GW-1:0] mag;
	logic is_zero, over_max, full, pop, not_empty;
	logic [EW-1:0] rdata;

	rgl_front #(.VALUE_WIDTH(VALUE_WIDTH), .GW(GW)) u_front (
		.value(value), .mag(mag), .is_zero(is_zero), .over_max(over_max)
	);

	assign in_ready = !full;

	rgl_fifo #(.WIDTH(EW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(in_valid && !full), .wdata({over_max, is_zero, last, mag}),
		.full(full), .pop(pop), .rdata(rdata), .not_empty(not_empty)
	);

	rgl_back #(.GW(GW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.item_valid(not_empty), .item_mag(rdata[GW-1:0]),
		.item_zero(rdata[GW+1]), .item_over(rdata[GW+2]), .item_last(rdata[GW]),
		.item_pop(pop), .out_valid(out_valid), .out_ready(out_ready),
		.gcd_result(gcd_result), .lcm_result(lcm_result), .lcm_overflow(lcm_overflow)
	);
endmodule
`default_nettype wire

### test/tb_running_gcd_lcm_reduce.sv
// Testbench for running_gcd_lcm_reduce: directed and random runs of signed values,
// results predicted by a scoreboard class and checked against the block's output.
// Depends on rgl_pkg and the running_gcd_lcm_reduce RTL.
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
	logic [31:0] gcd;
	logic [30:0] lcm;
	logic        ovf;
} reduce_res_t;

class gcd_lcm_scoreboard;
	logic [31:0] gcd_acc;
	logic [30:0] lcm_acc;
	bit          started;
	bit          ovf_seen;
	reduce_res_t pending[$];
	int          mismatches;
	int          results_seen;

	function new();
		gcd_acc = '0;
		lcm_acc = '0;
		started = 1'b0;
		ovf_seen = 1'b0;
		mismatches = 0;
		results_seen = 0;
	endfunction

	function logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	// Fold one accepted transaction into the running state.
	function void note_input(logic [31:0] v, logic lst);
		logic [63:0] m, g, q, l;
		reduce_res_t r;
		m = v[31] ? {32'd0, (~v + 32'd1)} : {32'd0, v};
		if (!started) begin
			gcd_acc = m[31:0];
			if (m > 64'h7FFF_FFFF) begin
				ovf_seen = 1'b1;
				lcm_acc = rgl_pkg::LCM_MAX;
			end else begin
				lcm_acc = m[30:0];
			end
			started = 1'b1;
		end else begin
			gcd_acc = 32'(euclid({32'd0, gcd_acc}, m));
			l = {33'd0, lcm_acc};
			if (l == 0 || m == 0) begin
				lcm_acc = '0;
			end else begin
				g = euclid(l, m);
				q = l / g;
				if (m > 64'h7FFF_FFFF / q) begin
					ovf_seen = 1'b1;
					lcm_acc = rgl_pkg::LCM_MAX;
				end else begin
					lcm_acc = 31'(q * m);
				end
			end
		end
		if (lst) begin
			r.gcd = gcd_acc;
			r.lcm = lcm_acc;
			r.ovf = ovf_seen;
			pending.push_back(r);
			gcd_acc = '0;
			lcm_acc = '0;
			started = 1'b0;
			ovf_seen = 1'b0;
		end
	endfunction

	// Compare one result against the oldest expectation.
	function void check_result(logic [31:0] g, logic [30:0] l, logic o);
		reduce_res_t e;
		results_seen++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result gcd=%0d lcm=%0d ovf=%0b", g, l, o);
			return;
		end
		e = pending.pop_front();
		if (e.gcd !== g || e.lcm !== l || e.ovf !== o) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp gcd=%0d lcm=%0d ovf=%0b, got gcd=%0d lcm=%0d ovf=%0b",
					e.gcd, e.lcm, e.ovf, g, l, o);
		end
	endfunction
endclass

module tb_running_gcd_lcm_reduce;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] value;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] gcd_result;
	logic [30:0] lcm_result;
	logic        lcm_overflow;

	gcd_lcm_scoreboard sb;
	bit          hold_off;
	int          items_sent;

	running_gcd_lcm_reduce #(.VALUE_WIDTH(32)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .value(value), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.gcd_result(gcd_result), .lcm_result(lcm_result), .lcm_overflow(lcm_overflow)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watch both handshakes at the rising edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_input(value, last);
		if (arst_n && out_valid && out_ready)
			sb.check_result(gcd_result, lcm_result, lcm_overflow);
	end

	// Offer one transaction, holding it until accepted; drop valid only for a gap.
	task automatic send_item(logic [31:0] v, logic lst, bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 17) : 0;
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		last <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		logic [31:0] base;
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h8000_0000;
			2: return 0;
			3: begin
				base = $urandom_range(1, 12);
				return base * $urandom_range(1, 2000) * ($urandom_range(0, 1) ? -1 : 1);
			end
			4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
			default: return $urandom_range(1, 300) * ($urandom_range(0, 1) ? 1 : -1);
		endcase
	endfunction

	// Receiver: random stalls, with one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int n, len, drain;
		sb = new();
		in_valid = 1'b0;
		value = '0;
		last = 1'b0;
		hold_off = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, single-item runs, zeros, saturation.
		send_item(32'h8000_0000, 1'b1, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b1, 1'b0);
		send_item(32'd0, 1'b1, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b1, 1'b0);
		send_item(32'd0, 1'b0, 1'b0);
		send_item(32'd0, 1'b1, 1'b0);
		send_item(32'd0, 1'b0, 1'b0);
		send_item(-12, 1'b1, 1'b0);
		send_item(32'd18, 1'b0, 1'b0);
		send_item(-24, 1'b0, 1'b0);
		send_item(32'd0, 1'b0, 1'b0);
		send_item(32'd36, 1'b1, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0, 1'b0);
		send_item(32'd2, 1'b0, 1'b0);
		send_item(32'd3, 1'b1, 1'b0);
		send_item(32'd65536, 1'b0, 1'b0);
		send_item(32'd65537, 1'b0, 1'b0);
		send_item(32'd0, 1'b1, 1'b0);
		send_item(32'h8000_0000, 1'b0, 1'b0);
		send_item(32'd6, 1'b1, 1'b0);
		send_item(32'h5555_5555, 1'b0, 1'b0);
		send_item(32'hAAAA_AAAA, 1'b1, 1'b0);

		// Long receiver hold-off while the sender keeps going.
		hold_off = 1'b1;
		fork
			begin
				repeat (3000) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int k = 0; k < 12; k++) send_item(rand_value(), 1'b1, 1'b0);
		join

		// Random runs of short length.
		n = 0;
		while (n < 870) begin
			len = $urandom_range(1, 5);
			for (int k = 0; k < len; k++)
				send_item(rand_value(), k == len - 1, 1'b1);
			n += len;
		end
		in_valid <= 1'b0;

		drain = 0;
		while (sb.pending.size() != 0 && drain < 200000) begin
			@(posedge clk);
			drain++;
		end
		repeat (300) @(posedge clk);
		$display("covered %0d input transactions and %0d results", items_sent,
			sb.results_seen);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches,
				sb.pending.size());
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#50ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
